// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file sbei_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, dropped while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant, checked during reset too.
`define ASSERT_HOLDS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ===== rtl/sbei_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbei_pkg;

  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_MAX_X = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_MAX_Y = 3'd3;

  // cycles from the accepting edge to the edge that takes the result
  localparam int LATENCY = 5;

  localparam int NUM_SIDES = 4;
  localparam int SIDE_BOTTOM = 0;
  localparam int SIDE_LEFT   = 1;
  localparam int SIDE_RIGHT  = 2;
  localparam int SIDE_TOP    = 3;

  localparam int NUM_CORNERS = 4;
  localparam int CORNER_LO = 0;  // (min_x, min_y)
  localparam int CORNER_LR = 1;  // (max_x, min_y)
  localparam int CORNER_HI = 2;  // (max_x, max_y)
  localparam int CORNER_UL = 3;  // (min_x, max_y)

  // end corners of each side, in side order
  localparam int SIDE_C0 [NUM_SIDES] = '{CORNER_LO, CORNER_LO, CORNER_HI, CORNER_HI};
  localparam int SIDE_C1 [NUM_SIDES] = '{CORNER_LR, CORNER_UL, CORNER_LR, CORNER_UL};

  // per-side flags worked out from compares alone
  typedef struct packed {
    logic rej;      // x or y extents strictly disjoint
    logic s2_zero;  // product of side orientations of p and q is zero
    logic s2_neg;   // ... and negative when not zero
  } side_flags_t;

  // sign of the segment orientation toward one corner
  typedef struct packed {
    logic neg;
    logic zero;
  } corner_sign_t;

endpackage

`default_nettype wire

// ===== rtl/segment_box_edge_intersect_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Segment vs. box-edge test, five register stages, one segment accepted per cycle.
// done is registered at the end of stage 5 after the accepting edge; throughput 1 beat/cycle.
// The depth is set by the 4 orientation multipliers and the wide subtract after them.
// Synchronous reset clears the stage valids and the box registers to 0; busy is high
// and cfg_ready low only while rst is high. The receiver cannot stall, so results
// never wait.

module segment_box_edge_intersect_core import sbei_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire signed [COORD_BITS-1:0]  start_x,
  input  wire signed [COORD_BITS-1:0]  start_y,
  input  wire signed [COORD_BITS-1:0]  end_x,
  input  wire signed [COORD_BITS-1:0]  end_y,
  output logic                         done,
  output logic                         crosses_edge,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire [COORD_BITS-1:0]         cfg_data
);

  localparam int DW = COORD_BITS + 1;  // coordinate difference
  localparam int PW = 2 * DW;          // product
  localparam int SW = PW + 1;          // difference of products

  logic signed [COORD_BITS-1:0] box_min_x, box_min_y, box_max_x, box_max_y;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_min_x <= cfg_data;
        REG_BOX_MIN_Y: box_min_y <= cfg_data;
        REG_BOX_MAX_X: box_max_x <= cfg_data;
        REG_BOX_MAX_Y: box_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic all_gt(input logic signed [COORD_BITS-1:0] a0,
                                  input logic signed [COORD_BITS-1:0] a1,
                                  input logic signed [COORD_BITS-1:0] b0,
                                  input logic signed [COORD_BITS-1:0] b1);
    return (a0 > b0) && (a0 > b1) && (a1 > b0) && (a1 > b1);
  endfunction

  function automatic logic apart(input logic signed [COORD_BITS-1:0] a0,
                                 input logic signed [COORD_BITS-1:0] a1,
                                 input logic signed [COORD_BITS-1:0] b0,
                                 input logic signed [COORD_BITS-1:0] b1);
    return all_gt(a0, a1, b0, b1) || all_gt(b0, b1, a0, a1);
  endfunction

  // ---- stage 1: input beat
  logic                         v1;
  logic signed [COORD_BITS-1:0] px, py, qx, qy;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
    px <= start_x;
    py <= start_y;
    qx <= end_x;
    qy <= end_y;
  end

  // ---- stage 2: differences and compare-only flags
  logic signed [DW-1:0] dqx_next, dqy_next, exl_next, exh_next, eyl_next, eyh_next;
  side_flags_t          sd_next [NUM_SIDES];
  logic                 w_zero, h_zero;

  always_comb begin
    dqx_next = {qx[COORD_BITS-1], qx} - {px[COORD_BITS-1], px};
    dqy_next = {qy[COORD_BITS-1], qy} - {py[COORD_BITS-1], py};
    exl_next = {box_min_x[COORD_BITS-1], box_min_x} - {px[COORD_BITS-1], px};
    exh_next = {box_max_x[COORD_BITS-1], box_max_x} - {px[COORD_BITS-1], px};
    eyl_next = {box_min_y[COORD_BITS-1], box_min_y} - {py[COORD_BITS-1], py};
    eyh_next = {box_max_y[COORD_BITS-1], box_max_y} - {py[COORD_BITS-1], py};

    // side orientation of a point is (side length sign) * (offset sign); the
    // length sign cancels in the product over p and q unless it is zero
    w_zero = (box_max_x == box_min_x);
    h_zero = (box_max_y == box_min_y);

    sd_next[SIDE_BOTTOM].s2_zero = w_zero || (py == box_min_y) || (qy == box_min_y);
    sd_next[SIDE_BOTTOM].s2_neg  = (py < box_min_y) ^ (qy < box_min_y);
    sd_next[SIDE_BOTTOM].rej     = apart(px, qx, box_min_x, box_max_x) ||
                                   apart(py, qy, box_min_y, box_min_y);

    sd_next[SIDE_LEFT].s2_zero   = h_zero || (px == box_min_x) || (qx == box_min_x);
    sd_next[SIDE_LEFT].s2_neg    = (px < box_min_x) ^ (qx < box_min_x);
    sd_next[SIDE_LEFT].rej       = apart(px, qx, box_min_x, box_min_x) ||
                                   apart(py, qy, box_min_y, box_max_y);

    sd_next[SIDE_RIGHT].s2_zero  = h_zero || (px == box_max_x) || (qx == box_max_x);
    sd_next[SIDE_RIGHT].s2_neg   = (px < box_max_x) ^ (qx < box_max_x);
    sd_next[SIDE_RIGHT].rej      = apart(px, qx, box_max_x, box_max_x) ||
                                   apart(py, qy, box_max_y, box_min_y);

    sd_next[SIDE_TOP].s2_zero    = w_zero || (py == box_max_y) || (qy == box_max_y);
    sd_next[SIDE_TOP].s2_neg     = (py < box_max_y) ^ (qy < box_max_y);
    sd_next[SIDE_TOP].rej        = apart(px, qx, box_max_x, box_min_x) ||
                                   apart(py, qy, box_max_y, box_max_y);
  end

  logic                 v2;
  logic signed [DW-1:0] dqx, dqy, exl, exh, eyl, eyh;
  side_flags_t          sd2 [NUM_SIDES];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    dqx <= dqx_next;
    dqy <= dqy_next;
    exl <= exl_next;
    exh <= exh_next;
    eyl <= eyl_next;
    eyh <= eyh_next;
    sd2 <= sd_next;
  end

  // ---- stage 3: products; orientation toward corner c is
  // dqx * (c.y - p.y) - dqy * (c.x - p.x)
  logic                 v3;
  logic signed [PW-1:0] m_xl, m_xh, m_yl, m_yh;
  side_flags_t          sd3 [NUM_SIDES];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    m_xl <= PW'(dqx) * PW'(eyl);
    m_xh <= PW'(dqx) * PW'(eyh);
    m_yl <= PW'(dqy) * PW'(exl);
    m_yh <= PW'(dqy) * PW'(exh);
    sd3  <= sd2;
  end

  // ---- stage 4: corner orientation signs
  logic signed [SW-1:0] od [NUM_CORNERS];
  corner_sign_t         cs_next [NUM_CORNERS];

  always_comb begin
    od[CORNER_LO] = {m_xl[PW-1], m_xl} - {m_yl[PW-1], m_yl};
    od[CORNER_LR] = {m_xl[PW-1], m_xl} - {m_yh[PW-1], m_yh};
    od[CORNER_HI] = {m_xh[PW-1], m_xh} - {m_yh[PW-1], m_yh};
    od[CORNER_UL] = {m_xh[PW-1], m_xh} - {m_yl[PW-1], m_yl};
    for (int c = 0; c < NUM_CORNERS; c++) begin
      cs_next[c].neg  = od[c][SW-1];
      cs_next[c].zero = (od[c] == '0);
    end
  end

  logic         v4;
  corner_sign_t cs4 [NUM_CORNERS];
  side_flags_t  sd4 [NUM_SIDES];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    cs4 <= cs_next;
    sd4 <= sd3;
  end

  // ---- stage 5: per-side decision and result
  logic hit_next;
  logic z1, le1, le2;

  always_comb begin
    hit_next = 1'b0;
    for (int s = 0; s < NUM_SIDES; s++) begin
      z1  = cs4[SIDE_C0[s]].zero || cs4[SIDE_C1[s]].zero;
      le1 = z1 || (cs4[SIDE_C0[s]].neg ^ cs4[SIDE_C1[s]].neg);
      le2 = sd4[s].s2_zero || sd4[s].s2_neg;
      // collinear pair with disjoint extents does not count
      if (le1 && le2 && !(z1 && sd4[s].s2_zero && sd4[s].rej))
        hit_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v4;
    crosses_edge <= hit_next;
  end

endmodule

`default_nettype wire

// ===== rtl/sbei_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbei_chk import sbei_pkg::*; (
  input wire clk,
  input wire rst,
  input wire start,
  input wire busy,
  input wire done
);

  // every accepted beat comes back as a done
  `ASSERT_IMPL(a_accept_done, clk, rst, start && !busy, ##LATENCY done, "accepted beat lost")

  // no result without an earlier accepted beat
  `ASSERT_IMPL(a_done_source, clk, rst, done, $past(start && !busy, LATENCY), "result invented")

  // reset flushes the pipeline at once
  `ASSERT_HOLDS(a_reset_flush, clk, rst || !$past(rst) || !done, "result after reset")

endmodule

bind segment_box_edge_intersect_core sbei_chk u_sbei_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire
